FILE: hdl/cas_pkg.sv
`default_nettype none

package cas_pkg;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } cas_time_t;

    localparam logic [3:0] MonthJan = 4'd1;
    localparam logic [3:0] MonthFeb = 4'd2;
    localparam logic [3:0] MonthDec = 4'd12;

    localparam logic [4:0] DaysLong = 5'd31;
    localparam logic [4:0] DaysLeapFeb = 5'd29;

    localparam logic [4:0] MonthLen [0:11] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // floor(x / 60), exact for x below 161319
    function automatic logic [11:0] div60_wide(input logic [17:0] x);
        logic [35:0] prod;
        prod = {18'd0, x} * 36'd139811;
        return prod[34:23];
    endfunction

    // floor(x / 60), exact for x below 4681
    function automatic logic [5:0] div60_narrow(input logic [11:0] x);
        logic [23:0] prod;
        prod = {12'd0, x} * 24'd2185;
        return prod[22:17];
    endfunction

    // x divisible by 25, exact over the full 14-bit range
    function automatic logic mult_of_25(input logic [13:0] x);
        logic [28:0] prod;
        logic [13:0] back;
        prod = {15'd0, x} * 29'd20972;
        back = 14'({4'd0, prod[28:19]} * 14'd25);
        return back == x;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/cas_core.sv
`default_nettype none

module cas_core (
    input  wire cas_pkg::cas_time_t start_time,
    input  wire logic [16:0]        offset_seconds,
    output cas_pkg::cas_time_t      end_time
);

    logic [17:0] acc0;
    logic [11:0] q1;
    logic [17:0] sec_wide;
    logic [11:0] acc1;
    logic [5:0]  q2;
    logic [11:0] min_wide;
    logic [6:0]  acc2;
    logic [6:0]  hour_wide;
    logic [1:0]  days;
    logic        leap;
    logic [4:0]  dim;
    logic [3:0]  month_idx;
    logic [5:0]  dsum;
    logic [5:0]  dwrap;
    logic        month_carry;

    always_comb begin
        acc0     = {1'b0, offset_seconds} + {12'd0, start_time.second};
        q1       = cas_pkg::div60_wide(acc0);
        sec_wide = acc0 - ({6'd0, q1} * 18'd60);

        acc1     = q1 + {6'd0, start_time.minute};
        q2       = cas_pkg::div60_narrow(acc1);
        min_wide = acc1 - ({6'd0, q2} * 12'd60);

        acc2 = {1'b0, q2} + {2'd0, start_time.hour};
        if (acc2 >= 7'd48) begin
            days      = 2'd2;
            hour_wide = acc2 - 7'd48;
        end else if (acc2 >= 7'd24) begin
            days      = 2'd1;
            hour_wide = acc2 - 7'd24;
        end else begin
            days      = 2'd0;
            hour_wide = acc2;
        end

        // divisible by 4, and not by 100 unless by 400
        leap = (start_time.year[1:0] == 2'd0) &&
               (!cas_pkg::mult_of_25(start_time.year) || (start_time.year[3:0] == 4'd0));

        month_idx = start_time.month - 4'd1;
        if (start_time.month == 4'd0 || start_time.month > cas_pkg::MonthDec) begin
            dim = cas_pkg::DaysLong;
        end else if (start_time.month == cas_pkg::MonthFeb && leap) begin
            dim = cas_pkg::DaysLeapFeb;
        end else begin
            dim = cas_pkg::MonthLen[month_idx];
        end

        dsum  = {1'b0, start_time.day} + {4'd0, days};
        dwrap = dsum - {1'b0, dim};

        end_time        = start_time;
        end_time.second = sec_wide[5:0];
        end_time.minute = min_wide[5:0];
        end_time.hour   = hour_wide[4:0];

        month_carry = 1'b0;
        if (days != 2'd0) begin
            if (dsum > {1'b0, dim}) begin
                end_time.day = dwrap[4:0];
                month_carry  = 1'b1;
            end else begin
                end_time.day = dsum[4:0];
            end
        end

        if (month_carry) begin
            if (start_time.month == cas_pkg::MonthDec) begin
                end_time.month = cas_pkg::MonthJan;
                end_time.year  = start_time.year + 14'd1;
            end else begin
                end_time.month = start_time.month + 4'd1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/calendar_add_seconds.sv
`default_nettype none

// channel  ports                                   direction
// input    s_valid, s_ready, s_start_*, s_offset_* in: start time and offset word
// result   m_valid, m_ready, m_end_*               out: end time word
//
// one word per cycle while s_ready is high; result appears in the cycle
// after the word is taken, via the single output register after the carry logic
// synchronous active-low reset clears m_valid only
// s_ready stays high while the output register is empty or being drained

module calendar_add_seconds (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [13:0] s_start_year,
    input  wire logic [3:0]  s_start_month,
    input  wire logic [4:0]  s_start_day,
    input  wire logic [4:0]  s_start_hour,
    input  wire logic [5:0]  s_start_minute,
    input  wire logic [5:0]  s_start_second,
    input  wire logic [16:0] s_offset_seconds,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [13:0]      m_end_year,
    output logic [3:0]       m_end_month,
    output logic [4:0]       m_end_day,
    output logic [4:0]       m_end_hour,
    output logic [5:0]       m_end_minute,
    output logic [5:0]       m_end_second
);

    cas_pkg::cas_time_t start_time;
    cas_pkg::cas_time_t end_time;
    cas_pkg::cas_time_t result_reg;
    logic               valid_reg;
    logic               valid_next;
    logic               take;

    assign start_time = '{
        year:   s_start_year,
        month:  s_start_month,
        day:    s_start_day,
        hour:   s_start_hour,
        minute: s_start_minute,
        second: s_start_second
    };

    cas_core u_core (
        .start_time     (start_time),
        .offset_seconds (s_offset_seconds),
        .end_time       (end_time)
    );

    assign s_ready = !valid_reg || m_ready;
    assign take    = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // result word
    always_ff @(posedge aclk) begin
        if (take) begin
            result_reg <= end_time;
        end
    end

    assign m_valid      = valid_reg;
    assign m_end_year   = result_reg.year;
    assign m_end_month  = result_reg.month;
    assign m_end_day    = result_reg.day;
    assign m_end_hour   = result_reg.hour;
    assign m_end_minute = result_reg.minute;
    assign m_end_second = result_reg.second;

endmodule

`default_nettype wire
